// ----- rtl/spp_pkg.sv -----
// shared constants, codes and the half-step coil table for the pointer positioner
package spp_pkg;

    localparam int unsigned ANGLE_W     = 16;
    localparam int unsigned DEADBAND_W  = 15;
    localparam int unsigned TICKS_W     = 16;
    localparam int unsigned STEPS_W     = 12;
    localparam int unsigned COIL_W      = 4;
    localparam int unsigned PHASE_W     = 3;
    localparam int unsigned CFG_DATA_W  = 16;

    localparam logic [DEADBAND_W-1:0] DEADBAND_RESET = DEADBAND_W'(500);
    localparam logic [TICKS_W-1:0]    TICKS_RESET    = TICKS_W'(15);

    localparam longint unsigned STEPS_PER_REV = 64'd4096;
    localparam longint unsigned FULL_TURN_CD  = 64'd36000;

    // wrapped difference, signed, wide enough for +/- two full turns
    localparam int unsigned DIFF_W = ANGLE_W + 2;
    localparam logic signed [DIFF_W-1:0] HALF_TURN     = DIFF_W'(18000);
    localparam logic signed [DIFF_W-1:0] FULL_TURN     = DIFF_W'(36000);
    localparam logic signed [DIFF_W-1:0] ONE_HALF_TURN = DIFF_W'(54000);
    localparam logic signed [DIFF_W-1:0] TWO_TURNS     = DIFF_W'(72000);

    // floor(mag * STEPS_PER_REV / FULL_TURN_CD) as one constant multiply and shift,
    // exact for any magnitude up to half a turn
    localparam int unsigned PROD_W      = 40;
    localparam int unsigned RECIP_SHIFT = 26;
    localparam longint unsigned RECIP_MULT =
        ((64'd1 << RECIP_SHIFT) * STEPS_PER_REV + FULL_TURN_CD - 64'd1) / FULL_TURN_CD;
    localparam logic [PROD_W-1:0] STEP_SCALE = PROD_W'(RECIP_MULT);
    localparam int unsigned QUOT_W = PROD_W - RECIP_SHIFT;
    localparam logic [QUOT_W-1:0] STEPS_MAX_Q = QUOT_W'({STEPS_W{1'b1}});

    typedef enum logic [0:0] {
        OP_TARGET = 1'b0,
        OP_TICK   = 1'b1
    } t_opcode;

    typedef enum logic [0:0] {
        CFG_DEADBAND = 1'b0,
        CFG_TICKS    = 1'b1
    } t_cfg_index;

    function automatic logic [COIL_W-1:0] half_step(input logic [PHASE_W-1:0] idx);
        logic [COIL_W-1:0] pat;
        case (idx)
            3'd0:    pat = 4'h9;
            3'd1:    pat = 4'h1;
            3'd2:    pat = 4'h3;
            3'd3:    pat = 4'h2;
            3'd4:    pat = 4'h6;
            3'd5:    pat = 4'h4;
            3'd6:    pat = 4'hC;
            3'd7:    pat = 4'h8;
            default: pat = 4'h0;
        endcase
        return pat;
    endfunction

endpackage

// ----- rtl/stepper_pointer_positioner.sv -----
// half-step stepper pointer positioner: target commands, tick pacing, coil drive
//
// Takes one word per clock on the input channel: a target command (opcode 0) or a
// tick (opcode 1), and returns exactly one result word for each. A word passes
// through an input register and then a result register; the throughput is one
// word per cycle, limited only by stall on the result side, which holds the
// result register and in the same cycle stalls the input. A command is taken
// only when no run is active, else it is refused and flagged. A run drives one
// half-step pattern every ticks_per_step ticks, the first on the first tick
// after the command, and the coils turn off one interval after the last step.
// Configuration writes are taken in any cycle (ready is always high) and are
// meant for idle periods.
module stepper_pointer_positioner (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_opcode,
    input  logic [spp_pkg::ANGLE_W-1:0]       i_target_angle,

    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [spp_pkg::COIL_W-1:0]        o_coil_pattern,
    output logic                              o_moving,
    output logic                              o_move_started,
    output logic                              o_command_refused,
    output logic [spp_pkg::ANGLE_W-1:0]       o_pointer_angle,
    output logic [spp_pkg::STEPS_W-1:0]       o_steps_remaining,

    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic                              i_cfg_index,
    input  logic [spp_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    logic [spp_pkg::DEADBAND_W-1:0] r_deadband;
    logic [spp_pkg::TICKS_W-1:0]    r_ticks_per_step;

    logic                           r_in_valid;
    spp_pkg::t_opcode               r_opcode;
    logic [spp_pkg::ANGLE_W-1:0]    r_target;

    logic [spp_pkg::ANGLE_W-1:0]    r_pointer_dir, n_pointer_dir;
    logic [spp_pkg::PHASE_W-1:0]    r_phase, n_phase;
    logic [spp_pkg::STEPS_W-1:0]    r_steps_left, n_steps_left;
    logic                           r_backward, n_backward;
    logic [spp_pkg::TICKS_W-1:0]    r_tick_count, n_tick_count;
    logic [spp_pkg::COIL_W-1:0]     r_coil, n_coil;

    logic                           r_out_valid;
    logic [spp_pkg::COIL_W-1:0]     r_out_coil;
    logic                           r_out_moving;
    logic                           r_out_started, n_started;
    logic                           r_out_refused, n_refused;
    logic [spp_pkg::ANGLE_W-1:0]    r_out_pointer;
    logic [spp_pkg::STEPS_W-1:0]    r_out_steps;

    logic                           advance;
    logic                           busy;
    logic signed [spp_pkg::DIFF_W-1:0] diff_raw;
    logic signed [spp_pkg::DIFF_W-1:0] diff_wrap;
    logic [spp_pkg::DIFF_W-1:0]     diff_abs;
    logic [spp_pkg::DEADBAND_W-1:0] mag;
    logic [spp_pkg::PROD_W-1:0]     prod;
    logic [spp_pkg::QUOT_W-1:0]     quot;
    logic [spp_pkg::STEPS_W-1:0]    step_count;
    logic [spp_pkg::TICKS_W-1:0]    reload;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadband       <= spp_pkg::DEADBAND_RESET;
            r_ticks_per_step <= spp_pkg::TICKS_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (spp_pkg::t_cfg_index'(i_cfg_index))
                spp_pkg::CFG_DEADBAND: r_deadband <= i_cfg_data[spp_pkg::DEADBAND_W-1:0];
                spp_pkg::CFG_TICKS:    r_ticks_per_step <= i_cfg_data[spp_pkg::TICKS_W-1:0];
                default: ;
            endcase
        end
    end

    // the result register frees up when empty or when its word is taken
    assign advance    = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_opcode <= spp_pkg::t_opcode'(i_opcode);
            r_target <= i_target_angle;
        end
    end

    assign busy = (r_steps_left != '0) || (r_coil != '0);

    // shortest signed error, wrapped into a half turn either way
    always_comb begin
        diff_raw = $signed({2'b00, r_target}) - $signed({2'b00, r_pointer_dir});
        if (diff_raw > spp_pkg::ONE_HALF_TURN) begin
            diff_wrap = diff_raw - spp_pkg::TWO_TURNS;
        end else if (diff_raw > spp_pkg::HALF_TURN) begin
            diff_wrap = diff_raw - spp_pkg::FULL_TURN;
        end else if (diff_raw < -spp_pkg::ONE_HALF_TURN) begin
            diff_wrap = diff_raw + spp_pkg::TWO_TURNS;
        end else if (diff_raw < -spp_pkg::HALF_TURN) begin
            diff_wrap = diff_raw + spp_pkg::FULL_TURN;
        end else begin
            diff_wrap = diff_raw;
        end
        diff_abs = diff_wrap[spp_pkg::DIFF_W-1] ? spp_pkg::DIFF_W'(-diff_wrap)
                                                : spp_pkg::DIFF_W'(diff_wrap);
        mag  = diff_abs[spp_pkg::DEADBAND_W-1:0];
        prod = spp_pkg::PROD_W'(mag) * spp_pkg::STEP_SCALE;
        quot = prod[spp_pkg::PROD_W-1:spp_pkg::RECIP_SHIFT];
        step_count = (quot > spp_pkg::STEPS_MAX_Q) ? '1 : quot[spp_pkg::STEPS_W-1:0];
        reload = (r_ticks_per_step == '0) ? '0 : r_ticks_per_step - 1'b1;
    end

    always_comb begin
        n_pointer_dir = r_pointer_dir;
        n_phase       = r_phase;
        n_steps_left  = r_steps_left;
        n_backward    = r_backward;
        n_tick_count  = r_tick_count;
        n_coil        = r_coil;
        n_started     = 1'b0;
        n_refused     = 1'b0;
        case (r_opcode)
            spp_pkg::OP_TARGET: begin
                if (busy) begin
                    n_refused = 1'b1;
                end else if (mag > r_deadband) begin
                    n_backward    = diff_wrap[spp_pkg::DIFF_W-1];
                    n_pointer_dir = r_target;
                    if (step_count != '0) begin
                        n_steps_left = step_count;
                        n_tick_count = '0;
                        n_started    = 1'b1;
                    end
                end
            end
            spp_pkg::OP_TICK: begin
                if (busy) begin
                    if (r_tick_count != '0) begin
                        n_tick_count = r_tick_count - 1'b1;
                    end else if (r_steps_left != '0) begin
                        n_coil       = spp_pkg::half_step(r_phase);
                        n_phase      = r_backward ? r_phase - 1'b1 : r_phase + 1'b1;
                        n_steps_left = r_steps_left - 1'b1;
                        n_tick_count = reload;
                    end else begin
                        n_coil = '0;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pointer_dir <= '0;
            r_phase       <= '0;
            r_steps_left  <= '0;
            r_backward    <= 1'b0;
            r_tick_count  <= '0;
            r_coil        <= '0;
            r_out_valid   <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_pointer_dir <= n_pointer_dir;
                r_phase       <= n_phase;
                r_steps_left  <= n_steps_left;
                r_backward    <= n_backward;
                r_tick_count  <= n_tick_count;
                r_coil        <= n_coil;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid) begin
            r_out_coil    <= n_coil;
            r_out_moving  <= (n_steps_left != '0) || (n_coil != '0);
            r_out_started <= n_started;
            r_out_refused <= n_refused;
            r_out_pointer <= n_pointer_dir;
            r_out_steps   <= n_steps_left;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_coil_pattern    = r_out_coil;
    assign o_moving          = r_out_moving;
    assign o_move_started    = r_out_started;
    assign o_command_refused = r_out_refused;
    assign o_pointer_angle   = r_out_pointer;
    assign o_steps_remaining = r_out_steps;

endmodule
